// ===== src/bqe_pkg.sv =====
// ----------------------------------------------------------------------------
// bqe_pkg : shared types and constants for the billboard quad expander
// Particle, basis and queue entry layouts, register indexes and the
// coefficients of the quarter-wave sine polynomial.
// ----------------------------------------------------------------------------
package bqe_pkg;

  localparam int ANGLE_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // register stages in the front pipeline, accept to queue push
  localparam int FRONT_STAGES = 9;

  // half vectors reach about 2^33 in magnitude
  localparam int HALF_W = 36;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UP_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UP_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UP_Z    = 3'd5;

  // Q1.14 one, also the reset value of the unit basis components
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  // sine polynomial z*(A + z^2*(B + z^2*C))
  localparam logic signed [15:0] SIN_A = 16'sd25736;
  localparam logic signed [15:0] SIN_B = -16'sd10512;
  localparam logic [10:0]        SIN_C = 11'd1160;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [31:0]        extent;
    logic [15:0]        tint_r;
    logic [15:0]        tint_g;
    logic [15:0]        tint_b;
    logic [15:0]        tint_a;
  } particle_t;

  typedef struct packed {
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } basis_t;

  // one classified particle: center, spun half vectors and color
  typedef struct packed {
    logic signed [31:0]       center_x;
    logic signed [31:0]       center_y;
    logic signed [31:0]       center_z;
    logic signed [HALF_W-1:0] half_rx;
    logic signed [HALF_W-1:0] half_ry;
    logic signed [HALF_W-1:0] half_rz;
    logic signed [HALF_W-1:0] half_ux;
    logic signed [HALF_W-1:0] half_uy;
    logic signed [HALF_W-1:0] half_uz;
    logic [15:0]              tint_r;
    logic [15:0]              tint_g;
    logic [15:0]              tint_b;
    logic [15:0]              tint_a;
  } quad_t;

endpackage

// ===== src/bqe_sine.sv =====
// ----------------------------------------------------------------------------
// bqe_sine : four-stage quarter-wave sine evaluator
// Evaluates the odd polynomial on a mirrored quarter-wave argument, clamps
// to [0, 1.0] in Q1.14 and applies the half-wave sign. One multiply a stage.
// ----------------------------------------------------------------------------
module bqe_sine #(
  parameter int QB = 14
) (
  input  logic                clk,
  input  logic [QB:0]         p_i,
  input  logic                neg_i,
  output logic signed [15:0]  s_o
);

  localparam int PW     = QB + 1;
  localparam int PROD_W = 16 + PW + 1;

  logic [PW-1:0]            p1_r, p2_r, p3_r;
  logic                     neg1_r, neg2_r, neg3_r;
  logic [PW-1:0]            z2_r, z2d_r;
  logic signed [15:0]       t_r, t2_r, s_r;

  logic [2*PW-1:0]          sq;
  logic [PW+10:0]           cz;
  logic [10:0]              cz_sh;
  logic signed [PROD_W-1:0] tz, tz_sh, sp, sp_sh;
  logic signed [15:0]       clamp;

  // per-stage arithmetic
  always_comb begin
    sq    = p_i * p_i;
    cz    = bqe_pkg::SIN_C * z2_r;
    cz_sh = cz[QB +: 11];
    tz    = t_r * $signed({1'b0, z2d_r});
    tz_sh = tz >>> QB;
    sp    = t2_r * $signed({1'b0, p3_r});
    sp_sh = sp >>> QB;
    priority if (sp_sh < 0) begin
      clamp = '0;
    end else if (sp_sh > bqe_pkg::ONE_Q14) begin
      clamp = bqe_pkg::ONE_Q14;
    end else begin
      clamp = sp_sh[15:0];
    end
  end

  // stage 1: z^2, stage 2: B + C z^2, stage 3: A + t z^2, stage 4: t2 z
  always_ff @(posedge clk) begin
    z2_r   <= sq[QB +: PW];
    p1_r   <= p_i;
    neg1_r <= neg_i;

    t_r    <= bqe_pkg::SIN_B + $signed({5'b0, cz_sh});
    z2d_r  <= z2_r;
    p2_r   <= p1_r;
    neg2_r <= neg1_r;

    t2_r   <= bqe_pkg::SIN_A + $signed(tz_sh[15:0]);
    p3_r   <= p2_r;
    neg3_r <= neg2_r;

    s_r    <= neg3_r ? -clamp : clamp;
  end

  assign s_o = s_r;

endmodule

// ===== src/bqe_front.sv =====
// ----------------------------------------------------------------------------
// bqe_front : particle classification pipeline
// Derives sine and cosine of the angle, spins the camera basis, scales it
// by half the extent and hands one queue word per particle to the queue.
// Never stalls; the top level holds back input by counting credits.
// ----------------------------------------------------------------------------
module bqe_front #(
  parameter int ANGLE_BITS = bqe_pkg::ANGLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc_i,
  input  logic [15:0]        angle_i,
  input  bqe_pkg::particle_t part_i,
  input  bqe_pkg::basis_t    basis_i,
  output logic               vld_o,
  output bqe_pkg::quad_t     quad_o
);

  localparam int QB  = ANGLE_BITS - 2;
  localparam int PW  = QB + 1;
  localparam int NST = bqe_pkg::FRONT_STAGES;
  localparam int HW  = bqe_pkg::HALF_W;

  logic [ANGLE_BITS-1:0] phase;
  logic [1:0]            quad_s, quad_c;
  logic [QB-1:0]         frac;
  logic [PW-1:0]         one_p, mirror;

  logic [PW-1:0]         ps_r, pc_r;
  logic                  negs_r, negc_r;
  logic [NST-1:0]        vld_r;
  bqe_pkg::particle_t    pay_r [NST];

  logic signed [15:0]    sn, cs;
  logic signed [15:0]    rv [3];
  logic signed [15:0]    uv [3];
  logic signed [31:0]    rc_r [3];
  logic signed [31:0]    us_r [3];
  logic signed [31:0]    uc_r [3];
  logic signed [31:0]    rs_r [3];
  logic signed [31:0]    rr_r [3];
  logic signed [31:0]    uu_r [3];
  logic [31:0]           ext6;
  logic signed [48:0]    rlo_r [3];
  logic signed [48:0]    rhi_r [3];
  logic signed [48:0]    ulo_r [3];
  logic signed [48:0]    uhi_r [3];
  logic signed [63:0]    rfull [3];
  logic signed [63:0]    ufull [3];
  logic signed [HW-1:0]  hr_r [3];
  logic signed [HW-1:0]  hu_r [3];

  // angle to phase of ANGLE_BITS bits
  if (ANGLE_BITS <= 16) begin : g_phase_narrow
    assign phase = angle_i[15 -: ANGLE_BITS];
  end else begin : g_phase_wide
    assign phase = {angle_i, {(ANGLE_BITS-16){1'b0}}};
  end

  // quadrant split; cosine is the sine a quarter turn ahead
  assign quad_s = phase[ANGLE_BITS-1 -: 2];
  assign quad_c = quad_s + 2'd1;
  assign frac   = phase[QB-1:0];
  assign one_p  = {1'b1, {QB{1'b0}}};
  assign mirror = one_p - {1'b0, frac};

  // valid shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NST-2:0], acc_i};
    end
  end

  // stage 0: quarter-wave arguments, payload line
  always_ff @(posedge clk) begin
    ps_r     <= quad_s[0] ? mirror : {1'b0, frac};
    negs_r   <= quad_s[1];
    pc_r     <= quad_c[0] ? mirror : {1'b0, frac};
    negc_r   <= quad_c[1];
    pay_r[0] <= part_i;
    for (int i = 1; i < NST; i++) begin
      pay_r[i] <= pay_r[i-1];
    end
  end

  // stages 1..4: sine and cosine
  bqe_sine #(.QB(QB)) u_sin (
    .clk   (clk),
    .p_i   (ps_r),
    .neg_i (negs_r),
    .s_o   (sn)
  );

  bqe_sine #(.QB(QB)) u_cos (
    .clk   (clk),
    .p_i   (pc_r),
    .neg_i (negc_r),
    .s_o   (cs)
  );

  always_comb begin
    rv[0] = basis_i.right_x;
    rv[1] = basis_i.right_y;
    rv[2] = basis_i.right_z;
    uv[0] = basis_i.up_x;
    uv[1] = basis_i.up_y;
    uv[2] = basis_i.up_z;
    ext6  = pay_r[6].extent;
  end

  // full-width products before the Q16.16 shift
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rfull[j] = (64'(rhi_r[j]) <<< 16) + 64'(rlo_r[j]);
      ufull[j] = (64'(uhi_r[j]) <<< 16) + 64'(ulo_r[j]);
    end
  end

  // stages 5..8: spin, sum, scale by extent halves, recombine
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      rc_r[j]  <= rv[j] * cs;
      us_r[j]  <= uv[j] * sn;
      uc_r[j]  <= uv[j] * cs;
      rs_r[j]  <= rv[j] * sn;

      rr_r[j]  <= rc_r[j] + us_r[j];
      uu_r[j]  <= uc_r[j] - rs_r[j];

      rlo_r[j] <= rr_r[j] * $signed({1'b0, ext6[15:0]});
      rhi_r[j] <= rr_r[j] * $signed({1'b0, ext6[31:16]});
      ulo_r[j] <= uu_r[j] * $signed({1'b0, ext6[15:0]});
      uhi_r[j] <= uu_r[j] * $signed({1'b0, ext6[31:16]});

      hr_r[j]  <= HW'(rfull[j] >>> 29);
      hu_r[j]  <= HW'(ufull[j] >>> 29);
    end
  end

  // queue word
  always_comb begin
    quad_o.center_x = pay_r[NST-1].center_x;
    quad_o.center_y = pay_r[NST-1].center_y;
    quad_o.center_z = pay_r[NST-1].center_z;
    quad_o.half_rx  = hr_r[0];
    quad_o.half_ry  = hr_r[1];
    quad_o.half_rz  = hr_r[2];
    quad_o.half_ux  = hu_r[0];
    quad_o.half_uy  = hu_r[1];
    quad_o.half_uz  = hu_r[2];
    quad_o.tint_r   = pay_r[NST-1].tint_r;
    quad_o.tint_g   = pay_r[NST-1].tint_g;
    quad_o.tint_b   = pay_r[NST-1].tint_b;
    quad_o.tint_a   = pay_r[NST-1].tint_a;
  end

  assign vld_o = vld_r[NST-1];

endmodule

// ===== src/bqe_queue.sv =====
// ----------------------------------------------------------------------------
// bqe_queue : short queue between front and back
// Register-based FIFO of classified particles. Room is guaranteed by the
// credit count at the input, so push never meets a full queue.
// ----------------------------------------------------------------------------
module bqe_queue #(
  parameter int DEPTH = bqe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  bqe_pkg::quad_t push_word_i,
  input  logic           pop_i,
  output logic           head_vld_o,
  output bqe_pkg::quad_t head_word_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  bqe_pkg::quad_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  // storage
  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_word_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign head_vld_o  = (count_r != '0);
  assign head_word_o = mem_r[rd_ptr_r];

endmodule

// ===== src/bqe_back.sv =====
// ----------------------------------------------------------------------------
// bqe_back : vertex emitter
// Walks the six corners of the head particle, one per cycle unless stalled,
// forms the saturated vertex position and holds it in the output register.
// ----------------------------------------------------------------------------
module bqe_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_vld_i,
  input  bqe_pkg::quad_t     head_word_i,
  output logic               pop_o,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_vert_x,
  output logic signed [31:0] out_vert_y,
  output logic signed [31:0] out_vert_z,
  output logic               out_tex_u,
  output logic               out_tex_v,
  output logic [15:0]        out_r,
  output logic [15:0]        out_g,
  output logic [15:0]        out_b,
  output logic [15:0]        out_a,
  output logic               out_last_vertex
);

  localparam int HW    = bqe_pkg::HALF_W;
  localparam int SUM_W = HW + 2;

  // corners bl, br, tr, bl, tr, tl; bit k is vertex k
  localparam logic [5:0] CORNER_U  = 6'b010110;
  localparam logic [5:0] CORNER_V  = 6'b001011;
  localparam logic [2:0] VERT_LAST = 3'd5;

  logic [2:0]         k_r;
  logic               load;
  logic               cu, cv;
  logic               out_valid_r;
  logic signed [31:0] vx_r, vy_r, vz_r;
  logic               tu_r, tv_r, last_r;
  logic [15:0]        cr_r, cg_r, cb_r, ca_r;

  // center +/- r +/- u, clamped to the signed 32-bit range
  function automatic logic signed [31:0] vert_coord(
    input logic signed [31:0]   ctr,
    input logic signed [HW-1:0] hr,
    input logic signed [HW-1:0] hu,
    input logic                 u_right,
    input logic                 v_bottom
  );
    logic signed [SUM_W-1:0] rt, ut, sum;
    logic signed [31:0]      res;
    rt  = SUM_W'(hr);
    ut  = SUM_W'(hu);
    sum = SUM_W'(ctr) + (u_right ? rt : -rt) + (v_bottom ? -ut : ut);
    priority if (sum > $signed(32'h7FFF_FFFF)) begin
      res = 32'sh7FFF_FFFF;
    end else if (sum < $signed(32'h8000_0000)) begin
      res = 32'sh8000_0000;
    end else begin
      res = sum[31:0];
    end
    return res;
  endfunction

  // output register takes a vertex whenever it is empty or being taken
  assign load  = head_vld_i && (!out_valid_r || !out_stall);
  assign pop_o = load && (k_r == VERT_LAST);
  assign cu    = CORNER_U[k_r];
  assign cv    = CORNER_V[k_r];

  // corner counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        k_r         <= (k_r == VERT_LAST) ? '0 : k_r + 3'd1;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // vertex word
  always_ff @(posedge clk) begin
    if (load) begin
      vx_r   <= vert_coord(head_word_i.center_x, head_word_i.half_rx,
                           head_word_i.half_ux, cu, cv);
      vy_r   <= vert_coord(head_word_i.center_y, head_word_i.half_ry,
                           head_word_i.half_uy, cu, cv);
      vz_r   <= vert_coord(head_word_i.center_z, head_word_i.half_rz,
                           head_word_i.half_uz, cu, cv);
      tu_r   <= cu;
      tv_r   <= cv;
      cr_r   <= head_word_i.tint_r;
      cg_r   <= head_word_i.tint_g;
      cb_r   <= head_word_i.tint_b;
      ca_r   <= head_word_i.tint_a;
      last_r <= (k_r == VERT_LAST);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_vert_x      = vx_r;
  assign out_vert_y      = vy_r;
  assign out_vert_z      = vz_r;
  assign out_tex_u       = tu_r;
  assign out_tex_v       = tv_r;
  assign out_r           = cr_r;
  assign out_g           = cg_r;
  assign out_b           = cb_r;
  assign out_a           = ca_r;
  assign out_last_vertex = last_r;

endmodule

// ===== src/billboard_quad_expander.sv =====
// ----------------------------------------------------------------------------
// billboard_quad_expander : rotated billboard to two-triangle quad
// Spins the camera basis by the particle angle, scales it by half the
// extent and emits six vertices bl, br, tr, bl, tr, tl per particle.
//
//   channel  direction  handshake          word
//   in_      input      in_valid/in_stall  center, extent, angle, tint
//   out_     output     out_valid/out_stall vertex, uv corner, tint, last flag
//   cfg_     input      cfg_valid/cfg_ready register index, 16-bit data
//
// One vertex per cycle while out_stall is low, set by the single vertex
// output register. A particle word passes the front pipeline, the queue
// and the output register. The front pipeline is 9 stages deep and never
// stops; in_stall rises when QUEUE_DEPTH particles are in the pipeline or
// the queue. Reset is synchronous; it restores the unit camera basis and
// empties the pipeline. cfg_ready is always high.
// ----------------------------------------------------------------------------
module billboard_quad_expander #(
  parameter int ANGLE_BITS  = bqe_pkg::ANGLE_BITS_DEF,
  parameter int QUEUE_DEPTH = bqe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [31:0]              in_center_x,
  input  logic signed [31:0]              in_center_y,
  input  logic signed [31:0]              in_center_z,
  input  logic [31:0]                     in_extent,
  input  logic [15:0]                     in_angle,
  input  logic [15:0]                     in_tint_r,
  input  logic [15:0]                     in_tint_g,
  input  logic [15:0]                     in_tint_b,
  input  logic [15:0]                     in_tint_a,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [31:0]              out_vert_x,
  output logic signed [31:0]              out_vert_y,
  output logic signed [31:0]              out_vert_z,
  output logic                            out_tex_u,
  output logic                            out_tex_v,
  output logic [15:0]                     out_r,
  output logic [15:0]                     out_g,
  output logic [15:0]                     out_b,
  output logic [15:0]                     out_a,
  output logic                            out_last_vertex,

  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bqe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                     cfg_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  bqe_pkg::basis_t    basis_r;
  bqe_pkg::particle_t part;
  bqe_pkg::quad_t     front_word, head_word;
  logic               in_acc;
  logic               front_vld;
  logic               head_vld;
  logic               q_pop;
  logic [CW-1:0]      credit_r, credit_nxt;

  assign cfg_ready = 1'b1;

  // camera basis registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      basis_r.right_x <= bqe_pkg::ONE_Q14;
      basis_r.right_y <= '0;
      basis_r.right_z <= '0;
      basis_r.up_x    <= '0;
      basis_r.up_y    <= bqe_pkg::ONE_Q14;
      basis_r.up_z    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bqe_pkg::REG_RIGHT_X: basis_r.right_x <= cfg_data;
        bqe_pkg::REG_RIGHT_Y: basis_r.right_y <= cfg_data;
        bqe_pkg::REG_RIGHT_Z: basis_r.right_z <= cfg_data;
        bqe_pkg::REG_UP_X:    basis_r.up_x    <= cfg_data;
        bqe_pkg::REG_UP_Y:    basis_r.up_y    <= cfg_data;
        bqe_pkg::REG_UP_Z:    basis_r.up_z    <= cfg_data;
        default:              basis_r         <= basis_r;
      endcase
    end
  end

  // credits cover every particle from accept until its last vertex is loaded
  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (credit_r == CW'(QUEUE_DEPTH));

  always_comb begin
    unique case ({in_acc, q_pop})
      2'b10:   credit_nxt = credit_r + CW'(1);
      2'b01:   credit_nxt = credit_r - CW'(1);
      default: credit_nxt = credit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_nxt;
    end
  end

  always_comb begin
    part.center_x = in_center_x;
    part.center_y = in_center_y;
    part.center_z = in_center_z;
    part.extent   = in_extent;
    part.tint_r   = in_tint_r;
    part.tint_g   = in_tint_g;
    part.tint_b   = in_tint_b;
    part.tint_a   = in_tint_a;
  end

  bqe_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc_i   (in_acc),
    .angle_i (in_angle),
    .part_i  (part),
    .basis_i (basis_r),
    .vld_o   (front_vld),
    .quad_o  (front_word)
  );

  bqe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (front_vld),
    .push_word_i (front_word),
    .pop_i       (q_pop),
    .head_vld_o  (head_vld),
    .head_word_o (head_word)
  );

  bqe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_vld_i      (head_vld),
    .head_word_i     (head_word),
    .pop_o           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_vert_x      (out_vert_x),
    .out_vert_y      (out_vert_y),
    .out_vert_z      (out_vert_z),
    .out_tex_u       (out_tex_u),
    .out_tex_v       (out_tex_v),
    .out_r           (out_r),
    .out_g           (out_g),
    .out_b           (out_b),
    .out_a           (out_a),
    .out_last_vertex (out_last_vertex)
  );

endmodule

// ===== src/bqe_checker.sv =====
// ----------------------------------------------------------------------------
// bqe_checker : port-level checks for the billboard quad expander
// Watches the vertex channel for quad framing and word stability.
// ----------------------------------------------------------------------------
module bqe_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [31:0]            out_vert_x,
  input logic signed [31:0]            out_vert_y,
  input logic signed [31:0]            out_vert_z,
  input logic                          out_tex_u,
  input logic                          out_tex_v,
  input logic [15:0]                   out_r,
  input logic [15:0]                   out_g,
  input logic [15:0]                   out_b,
  input logic [15:0]                   out_a,
  input logic                          out_last_vertex
);

  // stalled vertex word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_vert_x) &&
      $stable(out_vert_y) && $stable(out_vert_z) && $stable(out_last_vertex))
    else $error("vertex word changed under stall");

  // the closing vertex is the top-left corner
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_vertex |-> !out_tex_u && !out_tex_v)
    else $error("last vertex is not the top-left corner");

  // a quad is emitted without gaps once it has started
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_vertex |=> out_valid)
    else $error("gap inside a quad");

  // all vertices of a quad carry the same color
  a_same_tint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_vertex |=>
      out_r == $past(out_r) && out_g == $past(out_g) &&
      out_b == $past(out_b) && out_a == $past(out_a))
    else $error("color changed inside a quad");

endmodule

bind billboard_quad_expander bqe_checker u_bqe_checker (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench : billboard quad expander
// Sends particle words into the block and checks every vertex word against
// typed-in golden corners or a bit-exact predictor: table sine, spun and
// scaled basis, saturated corners, uv corners, tint copy and last flag. A
// directed table comes first, then random particles under several camera
// bases, written while the block is idle. Both channels idle at random,
// and one long receiver hold fills the block.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ANGLE_W       = 16;
  localparam int QW            = ANGLE_W - 2;
  localparam int VERTS_PER_QUAD = 6;
  localparam int PHASES        = 7;
  localparam int PRESSURE_PHASE = 4;
  localparam int RANDOM_ITEMS  = 35;
  localparam int PRESSURE_ITEMS = 12;
  localparam int HOLD_CYCLES   = 200;
  localparam int DRAIN_CYCLES  = 40;
  localparam int REPORT_LIMIT  = 10;

  // sine polynomial, Q1.14
  localparam longint POLY_A = 25736;
  localparam longint POLY_B = -10512;
  localparam longint POLY_C = 1160;
  localparam longint UNIT   = 16384;
  localparam logic [15:0] QUARTER_TURN = 16'h4000;

  // corner order bl, br, tr, bl, tr, tl (bit k is vertex k)
  localparam logic [5:0] CORNER_U = 6'b010110;
  localparam logic [5:0] CORNER_V = 6'b001011;

  // indexes past the register list, ignored by the block
  localparam logic [bqe_pkg::CFG_IDX_W-1:0] REG_SPARE_A = bqe_pkg::REG_UP_Z + 3'd1;
  localparam logic [bqe_pkg::CFG_IDX_W-1:0] REG_SPARE_B = bqe_pkg::REG_UP_Z + 3'd2;

  typedef struct packed {
    bqe_pkg::particle_t body;
    logic [15:0]        angle;
  } particle_word_t;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic               tu;
    logic               tv;
    logic [15:0]        r;
    logic [15:0]        g;
    logic [15:0]        b;
    logic [15:0]        a;
    logic               last;
  } vertex_t;

  // directed row: golden rows carry the bl and tr corners typed in
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [31:0]        extent;
    logic [15:0]        angle;
    logic [63:0]        rgba;
    logic               golden;
    logic signed [31:0] bl_x;
    logic signed [31:0] tr_x;
    logic signed [31:0] bl_y;
    logic signed [31:0] tr_y;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_center_x;
  logic signed [31:0] in_center_y;
  logic signed [31:0] in_center_z;
  logic [31:0]        in_extent;
  logic [15:0]        in_angle;
  logic [15:0]        in_tint_r;
  logic [15:0]        in_tint_g;
  logic [15:0]        in_tint_b;
  logic [15:0]        in_tint_a;

  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_vert_x;
  logic signed [31:0] out_vert_y;
  logic signed [31:0] out_vert_z;
  logic               out_tex_u;
  logic               out_tex_v;
  logic [15:0]        out_r;
  logic [15:0]        out_g;
  logic [15:0]        out_b;
  logic [15:0]        out_a;
  logic               out_last_vertex;

  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [bqe_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0]                   cfg_data;

  // camera basis as the block should hold it, by register index
  logic signed [15:0] cam_basis [6];
  vertex_t pending_verts [$];
  int  mismatches = 0;
  bit  calm = 1'b0;
  bit  sink_hold_req = 1'b0;

  localparam logic [bqe_pkg::CFG_IDX_W-1:0] BASIS_INDEX [6] = '{
    bqe_pkg::REG_RIGHT_X, bqe_pkg::REG_RIGHT_Y, bqe_pkg::REG_RIGHT_Z,
    bqe_pkg::REG_UP_X, bqe_pkg::REG_UP_Y, bqe_pkg::REG_UP_Z
  };

  plan_row_t plan [22] = '{
    // reset basis, unit quad at the origin
    '{32'sh0, 32'sh0, 32'sh0, 32'h0002_0000, 16'h0000, 64'h0000_FFFF_0000_FFFF,
      1'b1, -32'sd65536, 32'sd65536, -32'sd65536, 32'sd65536},
    // zero extent collapses onto the center
    '{32'sh1234_5678, -32'sd5, 32'sd7, 32'h0, 16'h1234, 64'hFFFF_0000_FFFF_0000,
      1'b1, 32'sh1234_5678, 32'sh1234_5678, -32'sd5, -32'sd5},
    // full extent, just short of saturation
    '{32'sh0, 32'sh0, 32'sh0, 32'hFFFF_FFFF, 16'h0000, 64'hAAAA_5555_AAAA_5555,
      1'b1, -32'sd2147483647, 32'sd2147483647, -32'sd2147483647, 32'sd2147483647},
    // full extent from the edges of the range, saturates per coordinate
    '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 16'h0000,
      64'h5555_AAAA_5555_AAAA,
      1'b1, 32'sh0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF},
    // half turn, negative half vectors floor to -2^31
    '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF, 16'h8000,
      64'h0001_0002_0004_0008,
      1'b1, 32'sh0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_FFFF},
    '{32'sh0, 32'sh0, 32'sh0, 32'h0002_0000, 16'h8000, 64'h8000_4000_2000_1000,
      1'b1, 32'sd65536, -32'sd65536, 32'sd65536, -32'sd65536},
    // smallest extent rounds down to nothing
    '{32'sd1, -32'sd1, 32'sh4000_0000, 32'h1, 16'h0000, 64'h1111_2222_4444_8888,
      1'b1, 32'sd1, 32'sd1, -32'sd1, -32'sd1},
    // smallest extent turned half way floors to minus one
    '{32'sh0, 32'sh0, 32'sh0, 32'h1, 16'h8000, 64'h0F0F_F0F0_00FF_FF00,
      1'b1, 32'sd1, -32'sd1, 32'sd1, -32'sd1},
    // the rest go through the predictor
    '{32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'h0002_0000, 16'h4000,
      64'h1234_5678_9ABC_DEF0, 1'b0, 32'sh0, 32'sh0, 32'sh0, 32'sh0},
    '{32'shFFFF_0000, 32'sh0000_8000, 32'sh0, 32'h0005_0000, 16'hC000,
      64'hFEDC_BA98_7654_3210, 1'b0, 32'sh0, 32'sh0, 32'sh0, 32'sh0},
    '{32'sh0, 32'sh0, 32'sh0, 32'h0010_0000, 16'hFFFF,
      64'h0000_0000_0000_0000, 1'b0, 32'sh0, 32'sh0, 32'sh0, 32'sh0},
    '{32'sh0, 32'sh0, 32'sh0, 32'hFFFF_FFFF, 16'h0001,
      64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'sh0, 32'sh0, 32'sh0, 32'sh0},
    '{-32'sh0003_0000, -32'sh0007_0000, 32'sh0001_0000, 32'h0003_0000, 16'h2000,
      64'h0102_0304_0506_0708, 1'b0, 32'sh0, 32'sh0, 32'sh0, 32'sh0},
    '{32'sh0100_0000, 32'sh0, -32'sh0100_0000, 32'h0001_8000, 16'h6000,
      64'hA5A5_5A5A_C3C3_3C3C, 1'b0, 32'sh0, 32'sh0, 32'sh0, 32'sh0},
    '{32'sh0, 32'sh7FFF_0000, 32'sh0, 32'h0040_0000, 16'hA000,
      64'h0001_0001_0001_0001, 1'b0, 32'sh0, 32'sh0, 32'sh0, 32'sh0},
    '{32'sh7FFF_0000, 32'sh8001_0000, 32'sh1234_0000, 32'hFFFF_FFFF, 16'hE000,
      64'h7FFF_8000_7FFF_8000, 1'b0, 32'sh0, 32'sh0, 32'sh0, 32'sh0},
    '{32'sh0, 32'sh0, 32'sh0, 32'h0100_0000, 16'h3FFF,
      64'h1357_9BDF_2468_ACE0, 1'b0, 32'sh0, 32'sh0, 32'sh0, 32'sh0},
    '{32'sh0, 32'sh0, 32'sh0, 32'h0100_0000, 16'h4001,
      64'h0F00_00F0_000F_F000, 1'b0, 32'sh0, 32'sh0, 32'sh0, 32'sh0},
    '{32'sh0, 32'sh0, 32'sh0, 32'h0100_0000, 16'hBFFF,
      64'hDEAD_BEEF_CAFE_F00D, 1'b0, 32'sh0, 32'sh0, 32'sh0, 32'sh0},
    '{32'sh0, 32'sh0, 32'sh0, 32'h0100_0000, 16'h7FFF,
      64'h0123_4567_89AB_CDEF, 1'b0, 32'sh0, 32'sh0, 32'sh0, 32'sh0},
    '{32'sh0, 32'sh0, 32'sh0, 32'h0100_0000, 16'h8001,
      64'h8421_4218_2184_1842, 1'b0, 32'sh0, 32'sh0, 32'sh0, 32'sh0},
    '{32'sh0050_0000, -32'sh0050_0000, 32'sh0, 32'h0007_3333, 16'h1555,
      64'h6666_9999_3333_CCCC, 1'b0, 32'sh0, 32'sh0, 32'sh0, 32'sh0}
  };

  billboard_quad_expander #(.ANGLE_BITS(ANGLE_W)) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_center_x     (in_center_x),
    .in_center_y     (in_center_y),
    .in_center_z     (in_center_z),
    .in_extent       (in_extent),
    .in_angle        (in_angle),
    .in_tint_r       (in_tint_r),
    .in_tint_g       (in_tint_g),
    .in_tint_b       (in_tint_b),
    .in_tint_a       (in_tint_a),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_vert_x      (out_vert_x),
    .out_vert_y      (out_vert_y),
    .out_vert_z      (out_vert_z),
    .out_tex_u       (out_tex_u),
    .out_tex_v       (out_tex_v),
    .out_r           (out_r),
    .out_g           (out_g),
    .out_b           (out_b),
    .out_a           (out_a),
    .out_last_vertex (out_last_vertex),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 10-unit clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // table sine over one quarter wave, Q1.14, floor at each step
  function automatic longint quarter_wave(longint p);
    longint z2, t, t2, s;
    z2 = (p * p) >>> QW;
    t  = POLY_B + ((POLY_C * z2) >>> QW);
    t2 = POLY_A + ((t * z2) >>> QW);
    s  = (t2 * p) >>> QW;
    if (s < 0) s = 0;
    if (s > UNIT) s = UNIT;
    return s;
  endfunction

  // full-turn sine from quadrant mirroring
  function automatic longint turn_sine(logic [ANGLE_W-1:0] phase);
    logic [1:0] quad;
    longint p, s;
    quad = phase[ANGLE_W-1 -: 2];
    p = phase & ((64'd1 << QW) - 1);
    s = quad[0] ? quarter_wave((64'sd1 <<< QW) - p) : quarter_wave(p);
    return quad[1] ? -s : s;
  endfunction

  function automatic logic signed [31:0] clamp_q16(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // queue one vertex of a quad
  function automatic void push_vertex(int k, logic signed [31:0] x, logic signed [31:0] y,
                                      logic signed [31:0] z, particle_word_t pw);
    vertex_t v;
    v.vx   = x;
    v.vy   = y;
    v.vz   = z;
    v.tu   = CORNER_U[k];
    v.tv   = CORNER_V[k];
    v.r    = pw.body.tint_r;
    v.g    = pw.body.tint_g;
    v.b    = pw.body.tint_b;
    v.a    = pw.body.tint_a;
    v.last = (k == VERTS_PER_QUAD - 1);
    pending_verts = {pending_verts, v};
  endfunction

  // spin the basis, scale by half the extent, emit the six corners
  function automatic void expand_particle(particle_word_t pw);
    longint sn, cs, ext, spin_r, spin_u, sr, su;
    longint half_r [3];
    longint half_u [3];
    longint ctr [3];
    logic signed [31:0] pos [3];
    sn  = turn_sine(pw.angle);
    cs  = turn_sine(pw.angle + QUARTER_TURN);
    ext = {32'b0, pw.body.extent};
    ctr[0] = longint'(pw.body.center_x);
    ctr[1] = longint'(pw.body.center_y);
    ctr[2] = longint'(pw.body.center_z);
    for (int j = 0; j < 3; j++) begin
      spin_r = longint'(cam_basis[j]) * cs + longint'(cam_basis[j + 3]) * sn;
      spin_u = longint'(cam_basis[j + 3]) * cs - longint'(cam_basis[j]) * sn;
      half_r[j] = (spin_r * ext) >>> 29;
      half_u[j] = (spin_u * ext) >>> 29;
    end
    for (int k = 0; k < VERTS_PER_QUAD; k++) begin
      sr = CORNER_U[k] ? 1 : -1;
      su = CORNER_V[k] ? -1 : 1;
      for (int j = 0; j < 3; j++)
        pos[j] = clamp_q16(ctr[j] + sr * half_r[j] + su * half_u[j]);
      push_vertex(k, pos[0], pos[1], pos[2], pw);
    end
  endfunction

  function automatic logic signed [31:0] random_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      2: begin
        if ($urandom_range(0, 1)) return 32'h7FFF_FFFF - $urandom_range(0, 32'h0004_0000);
        return 32'h8000_0000 + $urandom_range(0, 32'h0004_0000);
      end
      default: return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
    endcase
  endfunction

  function automatic particle_word_t random_particle();
    particle_word_t pw;
    pw.body.center_x = random_coord();
    pw.body.center_y = random_coord();
    pw.body.center_z = random_coord();
    case ($urandom_range(0, 7))
      0:       pw.body.extent = 32'h0;
      1, 2:    pw.body.extent = $urandom;
      3:       pw.body.extent = $urandom_range(1, 16);
      default: pw.body.extent = $urandom_range(0, 32'h00FF_FFFF);
    endcase
    // a quarter of the angles sit within two steps of a quadrant boundary
    if ($urandom_range(0, 3) == 0)
      pw.angle = 16'(($urandom_range(0, 3) << 14) + $urandom_range(0, 4) - 2);
    else
      pw.angle = 16'($urandom);
    pw.body.tint_r = 16'($urandom);
    pw.body.tint_g = 16'($urandom);
    pw.body.tint_b = 16'($urandom);
    pw.body.tint_a = 16'($urandom);
    return pw;
  endfunction

  // drive one particle word and hold it until taken
  task automatic offer_particle(particle_word_t pw);
    in_valid    <= 1'b1;
    in_center_x <= pw.body.center_x;
    in_center_y <= pw.body.center_y;
    in_center_z <= pw.body.center_z;
    in_extent   <= pw.body.extent;
    in_angle    <= pw.angle;
    in_tint_r   <= pw.body.tint_r;
    in_tint_g   <= pw.body.tint_g;
    in_tint_b   <= pw.body.tint_b;
    in_tint_a   <= pw.body.tint_a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // random sender gap
  task automatic sender_pause();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // drop valid and wait for every expected vertex
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_verts.size() != 0) @(posedge clk);
  endtask

  // register write; cfg_valid is left high for a following write
  task automatic write_reg(logic [bqe_pkg::CFG_IDX_W-1:0] idx, logic [15:0] word);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= bqe_pkg::REG_UP_Z) cam_basis[idx] = word;
  endtask

  // new camera basis for a phase
  task automatic program_basis(int ph);
    logic [15:0] word;
    for (int i = 0; i < 6; i++) begin
      case (ph)
        1:       word = 16'h4000;                    // +1.0 everywhere
        2:       word = 16'hC000;                    // -1.0 everywhere
        3:       word = i[0] ? 16'h8000 : 16'h7FFF;  // the ends of the Q2.14 range
        4, 6:    word = 16'($urandom_range(0, 32768) - 16384);
        default: word = 16'($urandom);
      endcase
      write_reg(BASIS_INDEX[i], word);
      // stray indexes must leave the basis alone
      if (ph == 3 && i == 2) begin
        write_reg(REG_SPARE_A, 16'($urandom));
        write_reg(REG_SPARE_B, 16'($urandom));
      end
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic string vertex_text(vertex_t v);
    return $sformatf("pos %h %h %h uv %b%b rgba %h %h %h %h last %b",
                     v.vx, v.vy, v.vz, v.tu, v.tv, v.r, v.g, v.b, v.a, v.last);
  endfunction

  // receiver pacing: random stall bursts, one long hold on request
  initial begin : sink_pacing
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // compare every accepted vertex word with the oldest expectation
  always @(posedge clk) begin : vertex_check
    vertex_t seen, want;
    if (rst_n && out_valid && !out_stall) begin
      seen = '{out_vert_x, out_vert_y, out_vert_z, out_tex_u, out_tex_v,
               out_r, out_g, out_b, out_a, out_last_vertex};
      if (pending_verts.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected vertex: %s", vertex_text(seen));
      end else begin
        want = pending_verts.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("vertex mismatch, expected %s", vertex_text(want));
            $display("                 actual   %s", vertex_text(seen));
          end
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    particle_word_t pw;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_center_x = '0;
    in_center_y = '0;
    in_center_z = '0;
    in_extent   = '0;
    in_angle    = '0;
    in_tint_r   = '0;
    in_tint_g   = '0;
    in_tint_b   = '0;
    in_tint_a   = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    cam_basis   = '{bqe_pkg::ONE_Q14, 16'sd0, 16'sd0, 16'sd0, bqe_pkg::ONE_Q14, 16'sd0};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        settle();
        program_basis(ph);
      end
      if (ph == PHASES - 1) calm = 1'b1;

      // directed table under the reset basis
      if (ph == 0) begin
        foreach (plan[i]) begin
          pw.body.center_x = plan[i].cx;
          pw.body.center_y = plan[i].cy;
          pw.body.center_z = plan[i].cz;
          pw.body.extent   = plan[i].extent;
          pw.body.tint_r   = plan[i].rgba[63:48];
          pw.body.tint_g   = plan[i].rgba[47:32];
          pw.body.tint_b   = plan[i].rgba[31:16];
          pw.body.tint_a   = plan[i].rgba[15:0];
          pw.angle         = plan[i].angle;
          offer_particle(pw);
          if (plan[i].golden) begin
            for (int k = 0; k < VERTS_PER_QUAD; k++)
              push_vertex(k, CORNER_U[k] ? plan[i].tr_x : plan[i].bl_x,
                          CORNER_V[k] ? plan[i].bl_y : plan[i].tr_y, plan[i].cz, pw);
          end else begin
            expand_particle(pw);
          end
          sender_pause();
        end
      end

      // receiver holds off while words keep coming, filling the block
      if (ph == PRESSURE_PHASE) begin
        sink_hold_req = 1'b1;
        repeat (PRESSURE_ITEMS) begin
          pw = random_particle();
          offer_particle(pw);
          expand_particle(pw);
        end
      end

      repeat (RANDOM_ITEMS) begin
        pw = random_particle();
        offer_particle(pw);
        expand_particle(pw);
        sender_pause();
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_verts.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  // run limit, several times the slowest legal run
  initial begin
    #4_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/bqe_pkg.sv
src/bqe_sine.sv
src/bqe_front.sv
src/bqe_queue.sv
src/bqe_back.sv
src/billboard_quad_expander.sv
src/bqe_checker.sv
tb/testbench.sv
